[rtl/drrip_pkg.sv]
package drrip_pkg;

    localparam int NUM_SETS    = 2048;
    localparam int NUM_WAYS    = 16;
    localparam int LEADER_SETS = 64;
    localparam int DUEL_WIDTH  = 10;
    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int ROW_W       = 2 * NUM_WAYS;
    localparam int TALLY_W     = 10;

    localparam logic [1:0] AGE_MAX  = 2'd3;
    localparam logic [1:0] LIVE_MAX = 2'd3;
    localparam logic [1:0] LIVE_RST = 2'd1;
    localparam logic [DUEL_WIDTH-1:0] DUEL_MAX = {DUEL_WIDTH{1'b1}};
    localparam logic [DUEL_WIDTH-1:0] DUEL_MID = DUEL_MAX >> 1;
    localparam logic [TALLY_W-1:0]    TALLY_MASK = 10'h3FF;
    localparam logic [4:0]            BIMODAL_MASK = 5'h1F;
    localparam logic [SET_W-1:0] SR_LAST  = SET_W'(LEADER_SETS - 1);
    localparam logic [SET_W-1:0] BR_FIRST = SET_W'(NUM_SETS - LEADER_SETS);

    localparam logic OP_VICTIM = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef logic [ROW_W-1:0] t_row;

    typedef struct packed {
        logic             we;
        logic [SET_W-1:0] addr;
        t_row             age;
        t_row             live;
    } t_row_wr;

endpackage

[rtl/drrip_row_ram.sv]
module drrip_row_ram (
    input  logic                      i_clk,
    input  logic                      i_re,
    input  logic [drrip_pkg::SET_W-1:0] i_raddr,
    input  drrip_pkg::t_row_wr        i_wr,
    output drrip_pkg::t_row           o_age,
    output drrip_pkg::t_row           o_live
);

    drrip_pkg::t_row r_age_mem  [drrip_pkg::NUM_SETS];
    drrip_pkg::t_row r_live_mem [drrip_pkg::NUM_SETS];
    drrip_pkg::t_row r_age_q;
    drrip_pkg::t_row r_live_q;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_age_mem[i_wr.addr]  <= i_wr.age;
            r_live_mem[i_wr.addr] <= i_wr.live;
        end
        if (i_re) begin
            r_age_q  <= r_age_mem[i_raddr];
            r_live_q <= r_live_mem[i_raddr];
        end
    end

    assign o_age  = r_age_q;
    assign o_live = r_live_q;

endmodule

[rtl/drrip_row_calc.sv]
module drrip_row_calc (
    input  drrip_pkg::t_row                   i_age,
    input  drrip_pkg::t_row                   i_live,
    input  logic                              i_op,
    input  logic [drrip_pkg::WAY_W-1:0]       i_way,
    input  logic                              i_hit,
    input  logic                              i_decay,
    input  logic                              i_ins3,
    output drrip_pkg::t_row                   o_age,
    output drrip_pkg::t_row                   o_live,
    output logic [drrip_pkg::WAY_W-1:0]       o_victim
);

    logic [1:0] top;
    logic [1:0] lift;
    logic [1:0] a;
    logic [1:0] l;
    logic       found;

    always_comb begin
        top = 2'd0;
        for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
            if (i_age[2*w +: 2] > top) top = i_age[2*w +: 2];
        end
        lift = drrip_pkg::AGE_MAX - top;
        o_age    = i_age;
        o_live   = i_live;
        o_victim = '0;
        found    = 1'b0;
        a        = 2'd0;
        l        = 2'd0;
        if (i_op == drrip_pkg::OP_VICTIM) begin
            for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
                a = i_age[2*w +: 2] + lift;
                o_age[2*w +: 2] = a;
                if (!found && a == drrip_pkg::AGE_MAX) begin
                    found = 1'b1;
                    o_victim = drrip_pkg::WAY_W'(w);
                end
            end
        end else if (i_decay) begin
            for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
                if (i_live[2*w +: 2] != 2'd0) o_live[2*w +: 2] = i_live[2*w +: 2] - 2'd1;
            end
        end else begin
            l = i_live[2*i_way +: 2];
            if (i_hit) begin
                o_age[2*i_way +: 2] = 2'd0;
                if (l < drrip_pkg::LIVE_MAX) o_live[2*i_way +: 2] = l + 2'd1;
            end else if (l == 2'd0 || i_ins3) begin
                o_age[2*i_way +: 2] = drrip_pkg::AGE_MAX;
            end else begin
                o_age[2*i_way +: 2] = drrip_pkg::AGE_MAX - 2'd1;
            end
        end
    end

endmodule

[rtl/drrip_dead_block_replacement_core.sv]
// a victim query passes S_READ and S_WRITE and strobes o_victim_valid for one cycle, registered from S_WRITE
// busy holds off a new transfer until the read, modify and write of one set row is done
// an update miss that wraps the access tally first decays every row, a read (S_DREAD) and
// a write (S_DWR) a row, then refetches its own row (S_FETCH)
// reset: i_rst_n synchronous; afterwards a clearing pass over all 2048 rows of the
// row memory, busy high throughout; the receiver cannot stall results
module drrip_dead_block_replacement_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_operation,
    input  logic [drrip_pkg::SET_W-1:0]     i_set_index,
    input  logic [drrip_pkg::WAY_W-1:0]     i_way_index,
    input  logic                            i_was_hit,
    output logic                            o_victim_valid,
    output logic [drrip_pkg::WAY_W-1:0]     o_victim_way
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_DREAD = 7'b0010000,
        S_DWR   = 7'b0100000,
        S_FETCH = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [drrip_pkg::SET_W-1:0]      r_set, r_ptr, n_ptr;
    logic [drrip_pkg::WAY_W-1:0]      r_way;
    logic                             r_op, r_hit;
    logic [drrip_pkg::TALLY_W-1:0]    r_tally, n_tally;
    logic [drrip_pkg::DUEL_WIDTH-1:0] r_duel, n_duel;
    logic                             r_vld;
    logic [drrip_pkg::WAY_W-1:0]      r_vway;

    logic                             acc, re;
    logic [drrip_pkg::SET_W-1:0]      raddr;
    drrip_pkg::t_row_wr               wr;
    drrip_pkg::t_row                  ram_age, ram_live, c_age, c_live;
    logic [drrip_pkg::WAY_W-1:0]      c_victim;
    logic                             lead_sr, lead_br, ins3, c_op, c_decay;

    assign busy = (r_state != S_IDLE);
    assign acc  = start && !busy;
    assign lead_sr = (r_set <= drrip_pkg::SR_LAST);
    assign lead_br = (r_set >= drrip_pkg::BR_FIRST);

    always_comb begin
        ins3 = 1'b0;
        if (!lead_sr && (lead_br || r_duel >= drrip_pkg::DUEL_MID)) begin
            ins3 = (r_tally[4:0] & drrip_pkg::BIMODAL_MASK) == 5'd0;
        end
    end

    drrip_row_ram u_ram (
        .i_clk  (i_clk),
        .i_re   (re),
        .i_raddr(raddr),
        .i_wr   (wr),
        .o_age  (ram_age),
        .o_live (ram_live)
    );

    assign c_op    = (r_state == S_DWR) ? drrip_pkg::OP_UPDATE : r_op;
    assign c_decay = (r_state == S_DWR);

    drrip_row_calc u_calc (
        .i_age   (ram_age),
        .i_live  (ram_live),
        .i_op    (c_op),
        .i_way   (r_way),
        .i_hit   (r_hit),
        .i_decay (c_decay),
        .i_ins3  (ins3),
        .o_age   (c_age),
        .o_live  (c_live),
        .o_victim(c_victim)
    );

    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_tally = r_tally;
        n_duel  = r_duel;
        re      = 1'b0;
        raddr   = r_set;
        wr.we   = 1'b0;
        wr.addr = r_set;
        wr.age  = c_age;
        wr.live = c_live;
        case (r_state)
            S_CLEAR: begin
                wr.we   = 1'b1;
                wr.addr = r_ptr;
                wr.age  = {drrip_pkg::NUM_WAYS{drrip_pkg::AGE_MAX}};
                wr.live = {drrip_pkg::NUM_WAYS{drrip_pkg::LIVE_RST}};
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == drrip_pkg::SET_W'(drrip_pkg::NUM_SETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    re    = 1'b1;
                    raddr = i_set_index;
                    if (i_operation == drrip_pkg::OP_VICTIM) n_state = S_READ;
                    else begin
                        n_state = S_READ;
                        n_tally = (r_tally + 1'b1) & drrip_pkg::TALLY_MASK;
                        if (!i_was_hit && n_tally == '0) begin
                            n_state = S_DREAD;
                            n_ptr   = '0;
                            re      = 1'b1;
                            raddr   = '0;
                        end
                    end
                end
            end
            S_DREAD: begin
                n_state = S_DWR;
            end
            S_DWR: begin
                wr.we   = 1'b1;
                wr.addr = r_ptr;
                n_ptr   = r_ptr + 1'b1;
                if (r_ptr == drrip_pkg::SET_W'(drrip_pkg::NUM_SETS - 1)) begin
                    n_state = S_FETCH;
                end else begin
                    re      = 1'b1;
                    raddr   = n_ptr;
                    n_state = S_DREAD;
                end
            end
            S_FETCH: begin
                re      = 1'b1;
                raddr   = r_set;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                wr.we   = 1'b1;
                n_state = S_IDLE;
                if (r_op == drrip_pkg::OP_UPDATE && !r_hit) begin
                    if (lead_sr && r_duel != drrip_pkg::DUEL_MAX) n_duel = r_duel + 1'b1;
                    else if (!lead_sr && lead_br && r_duel != '0) n_duel = r_duel - 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_ptr        <= '0;
            r_tally      <= '0;
            r_duel       <= drrip_pkg::DUEL_MID;
            r_vld        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_ptr        <= n_ptr;
            r_tally      <= n_tally;
            r_duel       <= n_duel;
            r_vld        <= (r_state == S_WRITE) && (r_op == drrip_pkg::OP_VICTIM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_operation;
            r_set <= i_set_index;
            r_way <= i_way_index;
            r_hit <= i_was_hit;
        end
        if (r_state == S_WRITE) r_vway <= c_victim;
    end

    assign o_victim_valid = r_vld;
    assign o_victim_way   = r_vway;

endmodule

[rtl/drrip_checker.sv]
module drrip_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_victim_valid,
    input logic [drrip_pkg::WAY_W-1:0] o_victim_way
);

    a_no_result_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_victim_valid) else $error("result after reset");

    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("not busy after reset");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_victim_valid |=> !o_victim_valid) else $error("strobe too long");

    a_busy_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("transfer did not raise busy");

    a_way_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_victim_valid |-> !$isunknown(o_victim_way)) else $error("victim way unknown");

endmodule

bind drrip_dead_block_replacement_core drrip_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_victim_valid(o_victim_valid),
    .o_victim_way  (o_victim_way)
);

[tb/drrip_dead_block_replacement_core_tb.sv]
`timescale 1ns / 1ps

module drrip_dead_block_replacement_core_tb;

    class victim_scoreboard;
        logic [1:0] ages[drrip_pkg::NUM_SETS*drrip_pkg::NUM_WAYS];
        logic [1:0] lives[drrip_pkg::NUM_SETS*drrip_pkg::NUM_WAYS];
        logic [drrip_pkg::DUEL_WIDTH-1:0] duel;
        logic [drrip_pkg::TALLY_W-1:0] tally;
        logic [drrip_pkg::WAY_W-1:0] pending_victims[$];
        int mismatches;
        int victims_seen;
        int updates;

        function new();
            for (int i = 0; i < drrip_pkg::NUM_SETS*drrip_pkg::NUM_WAYS; i++) begin
                ages[i] = drrip_pkg::AGE_MAX;
                lives[i] = drrip_pkg::LIVE_RST;
            end
            duel = drrip_pkg::DUEL_MID;
            tally = '0;
            mismatches = 0;
            victims_seen = 0;
            updates = 0;
        endfunction

        function logic [drrip_pkg::WAY_W-1:0] age_set_and_pick(int s);
            logic [1:0] top;
            logic [1:0] lift;
            top = 0;
            for (int w = 0; w < drrip_pkg::NUM_WAYS; w++)
                if (ages[s*drrip_pkg::NUM_WAYS+w] > top) top = ages[s*drrip_pkg::NUM_WAYS+w];
            lift = drrip_pkg::AGE_MAX - top;
            for (int w = 0; w < drrip_pkg::NUM_WAYS; w++)
                ages[s*drrip_pkg::NUM_WAYS+w] = ages[s*drrip_pkg::NUM_WAYS+w] + lift;
            for (int w = 0; w < drrip_pkg::NUM_WAYS; w++)
                if (ages[s*drrip_pkg::NUM_WAYS+w] == drrip_pkg::AGE_MAX)
                    return drrip_pkg::WAY_W'(w);
            return '0;
        endfunction

        function void note_transfer(logic op, logic [drrip_pkg::SET_W-1:0] s,
                                    logic [drrip_pkg::WAY_W-1:0] w, logic hit);
            int idx;
            logic sr, br;
            idx = int'(s) * drrip_pkg::NUM_WAYS + int'(w);
            sr = s <= drrip_pkg::SR_LAST;
            br = s >= drrip_pkg::BR_FIRST;
            if (op == drrip_pkg::OP_VICTIM) begin
                pending_victims.push_back(age_set_and_pick(int'(s)));
                return;
            end
            updates++;
            tally = tally + 1'b1;
            if (hit) begin
                ages[idx] = 2'd0;
                if (lives[idx] < drrip_pkg::LIVE_MAX) lives[idx] = lives[idx] + 1'b1;
                return;
            end
            if (tally == 0) begin
                for (int i = 0; i < drrip_pkg::NUM_SETS*drrip_pkg::NUM_WAYS; i++)
                    if (lives[i] > 0) lives[i] = lives[i] - 1'b1;
            end
            if (lives[idx] == 0)
                ages[idx] = drrip_pkg::AGE_MAX;
            else if (sr || (!br && duel < drrip_pkg::DUEL_MID))
                ages[idx] = drrip_pkg::AGE_MAX - 1'b1;
            else
                ages[idx] = (tally[4:0] == 5'd0) ? drrip_pkg::AGE_MAX
                                                 : drrip_pkg::AGE_MAX - 1'b1;
            if (sr) begin
                if (duel != drrip_pkg::DUEL_MAX) duel = duel + 1'b1;
            end else if (br) begin
                if (duel != 0) duel = duel - 1'b1;
            end
        endfunction

        function void check_victim(logic [drrip_pkg::WAY_W-1:0] got);
            logic [drrip_pkg::WAY_W-1:0] want;
            victims_seen++;
            if (pending_victims.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected victim %0d", got);
                return;
            end
            want = pending_victims.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("victim mismatch: expected %0d got %0d", want, got);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, start, busy;
    logic i_operation, i_was_hit;
    logic [drrip_pkg::SET_W-1:0] i_set_index;
    logic [drrip_pkg::WAY_W-1:0] i_way_index;
    logic o_victim_valid;
    logic [drrip_pkg::WAY_W-1:0] o_victim_way;
    victim_scoreboard sb;
    bit quiet;

    drrip_dead_block_replacement_core DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge i_clk)
        if (i_rst_n && o_victim_valid) sb.check_victim(o_victim_way);

    task automatic send(logic op, logic [drrip_pkg::SET_W-1:0] s,
                        logic [drrip_pkg::WAY_W-1:0] w, logic hit);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 18);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_set_index <= s;
        i_way_index <= w;
        i_was_hit <= hit;
        do @(posedge i_clk); while (busy);
        sb.note_transfer(op, s, w, hit);
    endtask

    function automatic logic [drrip_pkg::SET_W-1:0] pick_set();
        case ($urandom_range(0, 4))
            0: return drrip_pkg::SET_W'($urandom_range(0, drrip_pkg::LEADER_SETS - 1));
            1: return drrip_pkg::SET_W'($urandom_range(
                   drrip_pkg::NUM_SETS - drrip_pkg::LEADER_SETS, drrip_pkg::NUM_SETS - 1));
            2: return drrip_pkg::SET_W'($urandom_range(0, 7) * 300 + 100);
            default: return drrip_pkg::SET_W'($urandom);
        endcase
    endfunction

    initial begin
        logic [drrip_pkg::SET_W-1:0] s;
        sb = new();
        quiet = 0;
        i_rst_n = 0;
        start = 0;
        i_operation = drrip_pkg::OP_VICTIM;
        i_set_index = '0;
        i_way_index = '0;
        i_was_hit = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, hit and miss, leader and follower sets
        send(drrip_pkg::OP_VICTIM, '0, '0, 0);
        send(drrip_pkg::OP_VICTIM, '1, '0, 0);
        send(drrip_pkg::OP_UPDATE, '0, '0, 1);
        send(drrip_pkg::OP_UPDATE, '0, '1, 0);
        send(drrip_pkg::OP_VICTIM, '0, '0, 0);
        send(drrip_pkg::OP_UPDATE, '1, '1, 0);
        send(drrip_pkg::OP_UPDATE, '1, '0, 1);
        send(drrip_pkg::OP_VICTIM, '1, '1, 1);
        send(drrip_pkg::OP_UPDATE, drrip_pkg::SET_W'(1000), 4'd5, 1);
        send(drrip_pkg::OP_UPDATE, drrip_pkg::SET_W'(1000), 4'd5, 1);
        send(drrip_pkg::OP_UPDATE, drrip_pkg::SET_W'(1000), 4'd5, 1);
        send(drrip_pkg::OP_VICTIM, drrip_pkg::SET_W'(1000), '0, 0);
        send(drrip_pkg::OP_UPDATE, drrip_pkg::SR_LAST, 4'd7, 0);
        send(drrip_pkg::OP_UPDATE, drrip_pkg::BR_FIRST, 4'd8, 0);
        send(drrip_pkg::OP_VICTIM, drrip_pkg::SR_LAST, '0, 0);
        send(drrip_pkg::OP_VICTIM, drrip_pkg::BR_FIRST, '0, 0);

        // random: working sets of misses, hits and victim queries
        for (int n = 0; n < 794; n++) begin
            if (n > 700) quiet = 1;
            s = pick_set();
            case ($urandom_range(0, 5))
                0, 1: send(drrip_pkg::OP_VICTIM, s, drrip_pkg::WAY_W'($urandom),
                           1'($urandom));
                2: send(drrip_pkg::OP_UPDATE, s, drrip_pkg::WAY_W'($urandom), 1'b1);
                default: send(drrip_pkg::OP_UPDATE, s, drrip_pkg::WAY_W'($urandom), 1'b0);
            endcase
        end
        quiet = 1;
        for (int n = 0; n < 40; n++)
            send(drrip_pkg::OP_VICTIM, drrip_pkg::SET_W'(n * 50), '0, 0);
        start <= 1'b0;

        for (int t = 0; t < 5000 && sb.pending_victims.size() != 0; t++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("checked %0d victim results against %0d updates, final duel %0d",
                 sb.victims_seen, sb.updates, sb.duel);
        if (sb.mismatches == 0 && sb.pending_victims.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d missing", sb.mismatches,
                     sb.pending_victims.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
